/* rtl/core/lru_page_replacement_unit_macros.svh */
// ----------------------------------------------------------------------------
// LRU page replacement unit assertion macros
// Shared concurrent checks, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_MACROS_SVH

// same-cycle implication
`define LPR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared types and fixed constants of the LRU page replacement unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int CFG_W     = 4;
    localparam int FAULT_W   = 32;

    localparam logic [CFG_W-1:0]   FRAME_LIMIT_RST = 4'd3;
    localparam logic [FAULT_W-1:0] FAULT_MAX       = '1;

    typedef struct packed {
        logic en;
        logic clr;
    } t_cell_ctl;

endpackage

/* rtl/core/lru_page_replacement_unit.sv */
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Results are registered: a result item appears in the cycle after its reference is taken.
// Throughput: one reference per cycle while the output is not stalled; the
// compare-and-shift ripple through the frame cells sets the cycle time.
// Reset: frames empty, fault count zero, frame limit 3; no clearing pass.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_unit_macros.svh"

module lru_page_replacement_unit #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lpr_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [PAGE_BITS-1:0]        i_page,
    input  logic                        i_final_access,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic                        o_victim_valid,
    output logic [PAGE_BITS-1:0]        o_victim_page,
    output logic [lpr_pkg::FAULT_W-1:0] o_fault_total,
    output logic                        o_run_done
);
    import lpr_pkg::*;

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [CFG_W-1:0]     r_frame_limit;
    logic [FAULT_W-1:0]   r_fault;
    logic [FAULT_W-1:0]   n_fault;
    logic                 r_out_valid;
    logic                 r_hit;
    logic                 r_victim_valid;
    logic [PAGE_BITS-1:0] r_victim_page;
    logic [FAULT_W-1:0]   r_fault_total;
    logic                 r_run_done;

    logic                  w_accept;
    logic [IDX_W-1:0]      w_lim_m1;
    logic                  w_hit;
    logic                  w_evict;
    logic [FAULT_W-1:0]    w_fault_inc;
    t_cell_ctl             w_ctl;
    logic [MAX_FRAMES-1:0] w_match;
    logic [MAX_FRAMES-1:0] w_valid;
    logic [MAX_FRAMES-1:0] w_nvalid;
    logic [MAX_FRAMES:0]   w_shift;
    logic [PAGE_BITS-1:0]  w_page [MAX_FRAMES];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_frame_limit == '0) begin
            w_lim_m1 = '0;
        end else if (32'(r_frame_limit) > 32'(MAX_FRAMES)) begin
            w_lim_m1 = IDX_W'(MAX_FRAMES - 1);
        end else begin
            w_lim_m1 = IDX_W'(r_frame_limit - CFG_W'(1));
        end
    end

    always_comb begin
        w_hit       = |w_match;
        w_evict     = !w_hit && w_valid[w_lim_m1] && w_valid[0];
        w_fault_inc = (w_hit || (r_fault == FAULT_MAX)) ? r_fault : r_fault + FAULT_W'(1);
        n_fault     = i_final_access ? '0 : w_fault_inc;
        w_ctl.en    = w_accept;
        w_ctl.clr   = i_final_access;
    end

    assign w_shift[0] = w_evict;

    for (genvar k = 0; k < MAX_FRAMES; k++) begin : g_cell
        logic                 w_next_valid;
        logic [PAGE_BITS-1:0] w_next_page;
        logic                 w_prev_nvalid;

        if (k == MAX_FRAMES - 1) begin : g_tail
            assign w_next_valid = 1'b0;
            assign w_next_page  = '0;
        end else begin : g_body
            assign w_next_valid = w_valid[k+1];
            assign w_next_page  = w_page[k+1];
        end

        if (k == 0) begin : g_head
            assign w_prev_nvalid = 1'b1;
        end else begin : g_link
            assign w_prev_nvalid = w_nvalid[k-1];
        end

        lpr_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_page        (i_page),
            .i_shift       (w_shift[k]),
            .i_next_valid  (w_next_valid),
            .i_next_page   (w_next_page),
            .i_prev_nvalid (w_prev_nvalid),
            .o_shift       (w_shift[k+1]),
            .o_nvalid      (w_nvalid[k]),
            .o_match       (w_match[k]),
            .o_valid       (w_valid[k]),
            .o_page        (w_page[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RST;
            r_fault       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_limit <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit          <= w_hit;
            r_victim_valid <= w_evict;
            r_victim_page  <= w_evict ? w_page[0] : '0;
            r_fault_total  <= w_fault_inc;
            r_run_done     <= i_final_access;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_victim_valid = r_victim_valid;
    assign o_victim_page  = r_victim_page;
    assign o_fault_total  = r_fault_total;
    assign o_run_done     = r_run_done;

    `LPR_ASSERT_IMPL(a_frames_packed, 1'b1, ((w_valid + MAX_FRAMES'(1)) & w_valid) == '0, "resident frames not contiguous")
    `LPR_ASSERT_NEXT(a_final_clears, w_accept && i_final_access, w_valid == '0 && r_fault == '0, "frames not cleared after final item")
    `LPR_ASSERT_IMPL(a_room_on_full, w_accept && (&w_valid), w_shift[MAX_FRAMES], "full frame list without a drop")
    `LPR_ASSERT_IMPL(a_hit_no_victim, o_out_valid && o_hit, !o_victim_valid && o_victim_page == '0, "victim reported on a hit")

endmodule

/* rtl/core/lpr_cell.sv */
// ----------------------------------------------------------------------------
// LRU frame cell
// One slot of the recency chain: holds a page, compares it with the
// reference, shifts toward the least recent end and takes an appended page.
// ----------------------------------------------------------------------------
module lpr_cell #(
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpr_pkg::t_cell_ctl   i_ctl,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic                 i_shift,
    input  logic                 i_next_valid,
    input  logic [PAGE_BITS-1:0] i_next_page,
    input  logic                 i_prev_nvalid,
    output logic                 o_shift,
    output logic                 o_nvalid,
    output logic                 o_match,
    output logic                 o_valid,
    output logic [PAGE_BITS-1:0] o_page
);
    import lpr_pkg::*;

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic                 n_valid;
    logic [PAGE_BITS-1:0] n_page;
    logic                 w_shift_here;
    logic                 w_valid_sh;
    logic [PAGE_BITS-1:0] w_page_sh;
    logic                 w_app;

    always_comb begin
        o_match      = r_valid && (r_page == i_page);
        w_shift_here = i_shift | o_match;
        w_valid_sh   = w_shift_here ? i_next_valid : r_valid;
        w_page_sh    = w_shift_here ? i_next_page  : r_page;
        w_app        = !w_valid_sh && i_prev_nvalid;
        n_valid      = i_ctl.clr ? 1'b0 : (w_valid_sh | w_app);
        n_page       = w_app ? i_page : w_page_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_page <= n_page;
        end
    end

    assign o_shift  = w_shift_here;
    assign o_nvalid = w_valid_sh;
    assign o_valid  = r_valid;
    assign o_page   = r_page;

endmodule
